// ===== sv/assert_macros.svh =====
// Assertion macros shared by the conflict manager RTL.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("conflict manager check failed");
`define TCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("conflict manager check failed");
`else
`define TCM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/tcm_pkg.sv =====
// Types and codes of the transaction conflict manager.
// No dependencies.
`default_nettype none
package tcm_pkg;
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;
    localparam logic [1:0] OP_COMMIT = 2'd3;

    localparam logic [1:0] RES_ACCEPTED  = 2'd0;
    localparam logic [1:0] RES_ABORTED   = 2'd1;
    localparam logic [1:0] RES_COMMITTED = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         thread;
        logic [4:0]         word_index;
        logic signed [31:0] write_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [1:0]         outcome;
        logic [7:0]         victim_mask;
    } t_out;

    typedef struct packed {
        logic load;
        logic exec;
        logic rd_finish;
        logic walk_start;
        logic walk_step;
        logic commit_finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic go_read;
        logic go_commit;
        logic walk_done;
        logic out_busy;
    } t_stat;
endpackage
`default_nettype wire

// ===== sv/tcm_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module tcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                    i_wdata,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                    o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/tcm_ctrl.sv =====
// Sequencer of the conflict manager: decode, read, commit walk, response.
// Depends on tcm_pkg.
`default_nettype none
module tcm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tcm_pkg::t_stat i_stat,
    output tcm_pkg::t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_RDATA, S_WALK, S_FIN, S_RESP
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.go_read) begin
                    n_state = S_RDATA;
                end else if (i_stat.go_commit) begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_WALK;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_RESP;
                end
            end
            S_RDATA: begin
                o_cmd.rd_finish = 1'b1;
                n_state         = S_RESP;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.commit_finish = 1'b1;
                n_state             = S_RESP;
            end
            S_RESP: begin
                // hold the result until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule
`default_nettype wire

// ===== sv/tcm_datapath.sv =====
// Datapath of the conflict manager: thread flags, bit sets, memories, result.
// Depends on tcm_pkg and tcm_ram.
`default_nettype none
module tcm_datapath #(
    parameter int THREADS = 8,
    parameter int WORDS   = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tcm_pkg::t_in  i_in_data,
    input  wire tcm_pkg::t_cmd i_cmd,
    output tcm_pkg::t_stat     o_stat,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output tcm_pkg::t_out      o_out_data
);
    localparam int TB = $clog2(THREADS);
    localparam int WB = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW = $clog2(WORDS + 1);
    localparam int VW = (THREADS > 8) ? THREADS : 8;

    tcm_pkg::t_in  r_item;
    tcm_pkg::t_out r_res;
    logic [THREADS-1:0] r_started, r_finished, r_aborted, r_retry;
    logic [WORDS-1:0]   r_rbits [THREADS];
    logic [WORDS-1:0]   r_wbits [THREADS];
    logic [WORDS-1:0]   r_sh_valid;
    logic [CW-1:0]      r_k;
    logic               r_wr_valid;
    logic [WB-1:0]      r_wr_k;

    logic [TB-1:0]      t_idx;
    logic [WB-1:0]      w_idx;
    logic               t_ok, w_ok, k_live;
    logic [THREADS-1:0] vic;
    logic [VW-1:0]      vic_ext;
    logic [31:0]        sh_rdata, def_rdata, rd_value;
    logic [31:0]        fwd_rdata [THREADS];
    logic               def_we;

    assign t_idx   = TB'(r_item.thread);
    assign w_idx   = WB'(r_item.word_index);
    assign t_ok    = 32'(r_item.thread) < 32'(THREADS);
    assign w_ok    = 32'(r_item.word_index) < 32'(WORDS);
    assign k_live  = r_k < CW'(WORDS);
    assign vic_ext = VW'(vic);

    always_comb begin
        for (int j = 0; j < THREADS; j++) begin
            vic[j] = (TB'(j) != t_idx) && r_started[j] && !r_finished[j]
                     && (|(r_rbits[j] & r_wbits[t_idx]));
        end
    end

    assign rd_value = r_retry[t_idx] ? fwd_rdata[t_idx]
                    : (r_sh_valid[w_idx] ? sh_rdata : 32'd0);

    assign def_we = i_cmd.exec && t_ok && !r_aborted[t_idx]
                    && (r_item.op == tcm_pkg::OP_WRITE) && w_ok;

    assign o_stat.go_read   = t_ok && !r_aborted[t_idx] && (r_item.op == tcm_pkg::OP_READ)
                              && w_ok;
    assign o_stat.go_commit = t_ok && !r_aborted[t_idx] && (r_item.op == tcm_pkg::OP_COMMIT);
    assign o_stat.walk_done = (r_k == CW'(WORDS));
    assign o_stat.out_busy  = o_out_valid && !i_out_ready;

    tcm_ram #(.WIDTH(32), .DEPTH(WORDS)) u_shared (
        .i_clk  (i_clk),
        .i_we   (r_wr_valid),
        .i_waddr(r_wr_k),
        .i_wdata(def_rdata),
        .i_raddr(w_idx),
        .o_rdata(sh_rdata)
    );

    tcm_ram #(.WIDTH(32), .DEPTH(1 << (TB + WB))) u_deferred (
        .i_clk  (i_clk),
        .i_we   (def_we),
        .i_waddr({t_idx, w_idx}),
        .i_wdata(r_item.write_value),
        .i_raddr({t_idx, r_k[WB-1:0]}),
        .o_rdata(def_rdata)
    );

    for (genvar g = 0; g < THREADS; g++) begin : g_fwd
        logic fwd_we;
        assign fwd_we = (i_cmd.rd_finish && (TB'(g) == t_idx))
                        || (r_wr_valid && vic[g] && r_rbits[g][r_wr_k]);
        tcm_ram #(.WIDTH(32), .DEPTH(WORDS)) u_fwd (
            .i_clk  (i_clk),
            .i_we   (fwd_we),
            .i_waddr(i_cmd.rd_finish ? w_idx : r_wr_k),
            .i_wdata(i_cmd.rd_finish ? rd_value : def_rdata),
            .i_raddr(w_idx),
            .o_rdata(fwd_rdata[g])
        );
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.walk_step && k_live) begin
            r_wr_k <= r_k[WB-1:0];
        end
        if (i_cmd.out_load) begin
            o_out_data <= r_res;
        end
        if (i_cmd.exec) begin
            r_res <= {32'd0,
                      ((t_ok && r_aborted[t_idx]) ? tcm_pkg::RES_ABORTED
                                                  : tcm_pkg::RES_ACCEPTED),
                      8'd0};
        end
        if (i_cmd.rd_finish) begin
            r_res <= {rd_value, tcm_pkg::RES_ACCEPTED, 8'd0};
        end
        if (i_cmd.commit_finish) begin
            r_res <= {32'd0, tcm_pkg::RES_COMMITTED, vic_ext[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= '0;
            r_finished  <= '0;
            r_aborted   <= '0;
            r_retry     <= '0;
            r_sh_valid  <= '0;
            r_k         <= '0;
            r_wr_valid  <= 1'b0;
            o_out_valid <= 1'b0;
            for (int j = 0; j < THREADS; j++) begin
                r_rbits[j] <= '0;
                r_wbits[j] <= '0;
            end
        end else begin
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            if (i_cmd.exec && t_ok && !r_aborted[t_idx]) begin
                case (r_item.op)
                    tcm_pkg::OP_BEGIN: begin
                        if (r_finished[t_idx]) begin
                            r_rbits[t_idx]    <= '0;
                            r_wbits[t_idx]    <= '0;
                            r_finished[t_idx] <= 1'b0;
                            r_retry[t_idx]    <= 1'b0;
                        end
                        r_started[t_idx] <= 1'b1;
                    end
                    tcm_pkg::OP_WRITE: begin
                        if (w_ok) begin
                            r_wbits[t_idx][w_idx] <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            // commit by an aborted thread: drop its sets and arm retry
            if (i_cmd.exec && t_ok && r_aborted[t_idx]
                && (r_item.op == tcm_pkg::OP_COMMIT)) begin
                r_rbits[t_idx]   <= '0;
                r_wbits[t_idx]   <= '0;
                r_aborted[t_idx] <= 1'b0;
                r_started[t_idx] <= 1'b0;
                r_retry[t_idx]   <= 1'b1;
            end

            if (i_cmd.rd_finish) begin
                r_rbits[t_idx][w_idx] <= 1'b1;
            end

            // walk: read the buffer at r_k, write back in the following cycle
            if (i_cmd.walk_start) begin
                r_k        <= '0;
                r_wr_valid <= 1'b0;
            end else if (i_cmd.walk_step) begin
                r_wr_valid <= k_live && r_wbits[t_idx][r_k[WB-1:0]];
                if (k_live) begin
                    r_k <= r_k + CW'(1);
                end
            end else begin
                r_wr_valid <= 1'b0;
            end
            if (r_wr_valid) begin
                r_sh_valid[r_wr_k] <= 1'b1;
            end

            if (i_cmd.commit_finish) begin
                r_aborted         <= r_aborted | vic;
                r_finished[t_idx] <= 1'b1;
                r_retry[t_idx]    <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/transaction_conflict_manager_top.sv =====
// Transaction conflict manager, committer wins. Begin, write and commit of
// an aborted thread pass decode and response, a read also the read-data
// state, and a live commit the walk and finish states: the commit walks
// every word of the committer's deferred-write buffer through one RAM read
// port, one word a cycle, writing shared memory and the forwarded stores of
// conflicting readers as it goes. One item is handled at a time; a new item
// is accepted while the previous result still waits in the output register.
// Depends on tcm_pkg, tcm_ctrl, tcm_datapath and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module transaction_conflict_manager_top #(
    parameter int THREADS = 8,
    parameter int WORDS   = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire tcm_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output tcm_pkg::t_out     o_out_data
);
    tcm_pkg::t_cmd  c_cmd;
    tcm_pkg::t_stat c_stat;

    tcm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (c_stat),
        .o_cmd     (c_cmd)
    );

    tcm_datapath #(.THREADS(THREADS), .WORDS(WORDS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (c_cmd),
        .o_stat     (c_stat),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

    `TCM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `TCM_ASSERT_NEXT(a_walk_then_finish, i_clk, i_rst_n, c_cmd.walk_step && c_stat.walk_done, c_cmd.commit_finish)
    `TCM_ASSERT_IMPL(a_one_command, i_clk, i_rst_n, 1'b1, $onehot0(c_cmd))
endmodule
`default_nettype wire

// ===== tb/transaction_conflict_manager_top_tb.sv =====
// Self-checking bench for the transaction conflict manager (committer wins).
// Drives begin/read/write/commit items, predicts each result in a behavioural
// model of the thread and memory state; depends on tcm_pkg and the top level.
`default_nettype none
module transaction_conflict_manager_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTHR = 8;
    localparam int NWRD = 32;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    tcm_pkg::t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    tcm_pkg::t_out o_out_data;

    transaction_conflict_manager_top #(.THREADS(NTHR), .WORDS(NWRD)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model state
    logic [31:0] mem_words [NWRD];
    logic [31:0] rd_set [NTHR];
    logic [31:0] wr_set [NTHR];
    logic [31:0] wbuf [NTHR][NWRD];
    logic [31:0] fwd [NTHR][NWRD];
    logic [31:0] fwd_valid [NTHR];
    logic aborted [NTHR];
    logic started [NTHR];
    logic finished [NTHR];
    logic retry [NTHR];

    tcm_pkg::t_out results_due [$];
    int   mismatches = 0;
    bit   quiet = 1'b0;      // no idling on either side
    bit   hold_rx = 1'b0;    // long receiver hold-off
    int   idle_cycles = 0;
    int   rx_gap = 0;

    function automatic tcm_pkg::t_out predict_tcm(tcm_pkg::t_in it);
        tcm_pkg::t_out r;
        int t, w;
        r = '0;
        t = it.thread;
        w = it.word_index;
        if (aborted[t] && it.op != tcm_pkg::OP_COMMIT) begin
            r.outcome = tcm_pkg::RES_ABORTED;
        end else if (it.op == tcm_pkg::OP_BEGIN) begin
            if (finished[t]) begin
                rd_set[t] = '0; wr_set[t] = '0;
                for (int k = 0; k < NWRD; k++) wbuf[t][k] = '0;
                finished[t] = 1'b0;
                retry[t] = 1'b0;
            end
            started[t] = 1'b1;
            r.outcome = tcm_pkg::RES_ACCEPTED;
        end else if (it.op == tcm_pkg::OP_READ) begin
            r.read_data = retry[t] ? fwd[t][w] : mem_words[w];
            rd_set[t][w] = 1'b1;
            fwd[t][w] = r.read_data;
            fwd_valid[t][w] = 1'b1;
            r.outcome = tcm_pkg::RES_ACCEPTED;
        end else if (it.op == tcm_pkg::OP_WRITE) begin
            wbuf[t][w] = it.write_value;
            wr_set[t][w] = 1'b1;
            r.outcome = tcm_pkg::RES_ACCEPTED;
        end else if (aborted[t]) begin
            rd_set[t] = '0; wr_set[t] = '0;
            for (int k = 0; k < NWRD; k++) wbuf[t][k] = '0;
            aborted[t] = 1'b0;
            started[t] = 1'b0;
            retry[t] = 1'b1;
            r.outcome = tcm_pkg::RES_ABORTED;
        end else begin
            for (int k = 0; k < NWRD; k++)
                if (wr_set[t][k]) mem_words[k] = wbuf[t][k];
            for (int j = 0; j < NTHR; j++) begin
                if (j == t || !started[j] || finished[j]) continue;
                for (int k = 0; k < NWRD; k++)
                    if (wr_set[t][k] && rd_set[j][k]) begin
                        aborted[j] = 1'b1;
                        fwd[j][k] = wbuf[t][k];
                        fwd_valid[j][k] = 1'b1;
                        r.victim_mask[j] = 1'b1;
                    end
            end
            finished[t] = 1'b1;
            retry[t] = 1'b0;
            r.outcome = tcm_pkg::RES_COMMITTED;
        end
        return r;
    endfunction

    // Avoid a retry read of a forwarded entry never written.
    function automatic tcm_pkg::t_in make_safe(tcm_pkg::t_in it);
        if (it.op == tcm_pkg::OP_READ && retry[it.thread] && !aborted[it.thread]
                && !fwd_valid[it.thread][it.word_index])
            it.op = tcm_pkg::OP_WRITE;
        return it;
    endfunction

    // Valid stays up between back-to-back items; drop it only for a gap.
    task automatic send_item(tcm_pkg::t_in it);
        tcm_pkg::t_in s;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s = make_safe(it);
        i_in_valid <= 1'b1;
        i_in_data <= s;
        do @(posedge i_clk); while (!o_in_ready);
        results_due.insert(results_due.size(), predict_tcm(s));
    endtask

    function automatic tcm_pkg::t_in mk(logic [1:0] op, int t, int w, logic [31:0] v);
        tcm_pkg::t_in it;
        it.op = op; it.thread = 3'(t); it.word_index = 5'(w); it.write_value = v;
        return it;
    endfunction

    function automatic tcm_pkg::t_in rand_item();
        return mk(2'($urandom_range(0, 3)), $urandom_range(0, NTHR - 1),
                  $urandom_range(0, NWRD - 1), $urandom);
    endfunction

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    // Receiver: random idle bursts, or held off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rx) begin
            i_out_ready <= 1'b0;
        end else if (quiet) begin
            i_out_ready <= 1'b1;
        end else if (rx_gap > 0) begin
            i_out_ready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            rx_gap <= $urandom_range(0, 9);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        tcm_pkg::t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                exp_r = results_due.pop_front();
                if (o_out_data.read_data !== exp_r.read_data ||
                    o_out_data.outcome !== exp_r.outcome ||
                    o_out_data.victim_mask !== exp_r.victim_mask) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %p got %p", exp_r, o_out_data);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("transaction_conflict_manager_top_tb failed");
            $finish;
        end
    end

    task automatic test_extremes();
        send_item(mk(tcm_pkg::OP_READ, 0, 0, 0));
        send_item(mk(tcm_pkg::OP_BEGIN, 0, 0, 0));
        send_item(mk(tcm_pkg::OP_BEGIN, 7, 0, 0));
        send_item(mk(tcm_pkg::OP_WRITE, 0, 31, 32'h7fffffff));
        send_item(mk(tcm_pkg::OP_WRITE, 0, 0, 32'h80000000));
        send_item(mk(tcm_pkg::OP_READ, 7, 31, 0));
        send_item(mk(tcm_pkg::OP_READ, 7, 0, 0));
        send_item(mk(tcm_pkg::OP_COMMIT, 0, 0, 0));
    endtask

    task automatic test_abort_retry();
        send_item(mk(tcm_pkg::OP_READ, 7, 31, 0));
        send_item(mk(tcm_pkg::OP_WRITE, 7, 5, 32'hffffffff));
        send_item(mk(tcm_pkg::OP_BEGIN, 7, 0, 0));
        send_item(mk(tcm_pkg::OP_COMMIT, 7, 0, 0));
        send_item(mk(tcm_pkg::OP_BEGIN, 7, 0, 0));
        send_item(mk(tcm_pkg::OP_READ, 7, 31, 0));
        send_item(mk(tcm_pkg::OP_COMMIT, 7, 0, 0));
        send_item(mk(tcm_pkg::OP_COMMIT, 7, 0, 0));
        send_item(mk(tcm_pkg::OP_BEGIN, 0, 0, 0));
        send_item(mk(tcm_pkg::OP_COMMIT, 0, 0, 0));
    endtask

    // Well-formed transactions on a few hot words, with noise mixed in.
    task automatic test_random(int count);
        tcm_pkg::t_in it;
        int t;
        for (int i = 0; i < count; i++) begin
            t = $urandom_range(0, NTHR - 1);
            if ($urandom_range(0, 4) == 0) begin
                it = rand_item();
            end else if (!started[t] || finished[t]) begin
                it = mk(tcm_pkg::OP_BEGIN, t, 0, 0);
            end else begin
                case ($urandom_range(0, 5))
                    0, 1: it = mk(tcm_pkg::OP_READ, t, $urandom_range(0, 7), 0);
                    2, 3: it = mk(tcm_pkg::OP_WRITE, t, $urandom_range(0, 7), $urandom);
                    default: it = mk(tcm_pkg::OP_COMMIT, t, 0, 0);
                endcase
            end
            send_item(it);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            test_random(12);
        join
        drain();
    endtask

    initial begin
        for (int k = 0; k < NWRD; k++) mem_words[k] = '0;
        for (int t = 0; t < NTHR; t++) begin
            rd_set[t] = '0; wr_set[t] = '0; fwd_valid[t] = '0;
            aborted[t] = 0; started[t] = 0; finished[t] = 0; retry[t] = 0;
            for (int k = 0; k < NWRD; k++) begin
                wbuf[t][k] = '0; fwd[t][k] = '0;
            end
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_abort_retry();
        test_random(300);
        drain();
        test_backpressure();
        test_random(250);
        quiet = 1'b1;
        test_random(80);
        drain();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("transaction_conflict_manager_top_tb passed");
        else
            $display("transaction_conflict_manager_top_tb failed");
        $finish;
    end
endmodule
`default_nettype wire
